// ===== rtl/core/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Shared widths, item and register codes, and frame-step structs.
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam int MAX_FRAMES   = 64;
    localparam int FRAME_BITS   = $clog2(MAX_FRAMES);
    localparam int LEN_BITS     = $clog2(MAX_FRAMES + 1);
    localparam int DUR_BITS     = 24;
    localparam int TIME_BITS    = 32;
    localparam int MAX_ADVANCES = 100000;
    localparam int ADV_BITS     = $clog2(MAX_ADVANCES + 1);

    localparam int IN_BITS  = 2 + DUR_BITS + FRAME_BITS + DUR_BITS;
    localparam int IN_BYTES = (IN_BITS + 7) / 8;
    localparam int OUT_BITS = FRAME_BITS + 2;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    // Item kinds
    localparam logic [1:0] ITEM_TICK    = 2'd0;
    localparam logic [1:0] ITEM_RESTART = 2'd1;
    localparam logic [1:0] ITEM_LOAD    = 2'd2;

    // Loop modes; the fourth code behaves as ping-pong
    localparam logic [1:0] LOOP_ONCE     = 2'd0;
    localparam logic [1:0] LOOP_WRAP     = 2'd1;
    localparam logic [1:0] LOOP_PINGPONG = 2'd2;

    // Register indexes
    localparam logic CFG_LOOP_MODE   = 1'b0;
    localparam logic CFG_FRAME_COUNT = 1'b1;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic [LEN_BITS-1:0]   len;
        logic [1:0]            loop_mode;
        logic                  fwd;
    } step_in_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic                  fwd;
        logic                  stop;
    } step_out_t;

endpackage

// ===== rtl/core/sfs_dur_ram.sv =====
// ----------------------------------------------------------------------------
// Frame duration RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sfs_dur_ram (
    input  logic                              clk,
    input  logic                              we,
    input  logic [sfs_pkg::FRAME_BITS-1:0]    waddr,
    input  logic [sfs_pkg::DUR_BITS-1:0]      wdata,
    input  logic                              re,
    input  logic [sfs_pkg::FRAME_BITS-1:0]    raddr,
    output logic [sfs_pkg::DUR_BITS-1:0]      rdata
);
    import sfs_pkg::*;

    logic [DUR_BITS-1:0] mem [MAX_FRAMES];
    logic [DUR_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sfs_frame_step.sv =====
// ----------------------------------------------------------------------------
// Frame step
// Next frame and direction for one advance under the selected loop mode.
// ----------------------------------------------------------------------------
module sfs_frame_step (
    input  sfs_pkg::step_in_t  step_in,
    output sfs_pkg::step_out_t step_out
);
    import sfs_pkg::*;

    logic [LEN_BITS-1:0]   last_full;
    logic [FRAME_BITS-1:0] last;
    logic [FRAME_BITS-1:0] f;

    assign last_full = step_in.len - LEN_BITS'(1);
    assign last      = last_full[FRAME_BITS-1:0];
    // a frame past the clip end advances as if from the last frame
    assign f         = (step_in.frame > last) ? last : step_in.frame;

    always_comb
    begin
        step_out.frame = f;
        step_out.fwd   = step_in.fwd;
        step_out.stop  = 1'b0;
        unique case (step_in.loop_mode)
            LOOP_ONCE:
            begin
                if (f < last)
                begin
                    step_out.frame = f + FRAME_BITS'(1);
                end
                else
                begin
                    step_out.stop = 1'b1;
                end
            end
            LOOP_WRAP:
            begin
                step_out.frame = (f == last) ? '0 : f + FRAME_BITS'(1);
            end
            default:
            begin
                if (step_in.len == LEN_BITS'(1))
                begin
                    step_out.frame = '0;
                end
                else if (step_in.fwd)
                begin
                    if (f == last)
                    begin
                        step_out.fwd   = 1'b0;
                        step_out.frame = f - FRAME_BITS'(1);
                    end
                    else
                    begin
                        step_out.frame = f + FRAME_BITS'(1);
                    end
                end
                else if (f == '0)
                begin
                    step_out.fwd   = 1'b1;
                    step_out.frame = FRAME_BITS'(1);
                end
                else
                begin
                    step_out.frame = f - FRAME_BITS'(1);
                end
            end
        endcase
    end

endmodule

// ===== rtl/core/sprite_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Load, restart, unknown and ignored tick items: accept, then ST_FINISH puts the
// result in m_tdata once the output register is free.
// Tick items: each frame advance is one duration RAM read and compare/subtract;
// the next read is issued while stepping, so advances run at one advance/cycle.
// One item in flight; the next is taken once its result sits in the output reg.
// Reset (rst_n, async) returns to frame 0, forward, playing, wrap loop mode, no clip.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata: mode[1:0], tick_time[25:2], entry_index[31:26],
    //          entry_duration[55:32]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sfs_pkg::IN_BYTES*8-1:0]       s_tdata,
    // m_tdata: frame_index[5:0], playing_flag[6], moving_forward[7]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sfs_pkg::OUT_BYTES*8-1:0]      m_tdata,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [sfs_pkg::LEN_BITS-1:0]         cfg_data
);
    import sfs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [TIME_BITS-1:0]  acc_reg, acc_next;
    logic                  fwd_reg, fwd_next;
    logic                  playing_reg, playing_next;
    logic [1:0]            loop_mode_reg, loop_mode_next;
    logic [LEN_BITS-1:0]   frame_count_reg, frame_count_next;
    logic [ADV_BITS-1:0]   adv_cnt_reg, adv_cnt_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_BYTES*8-1:0] m_tdata_reg, m_tdata_next;

    logic [1:0]            in_mode;
    logic [DUR_BITS-1:0]   in_tick;
    logic [FRAME_BITS-1:0] in_index;
    logic [DUR_BITS-1:0]   in_dur;
    logic                  in_accept;

    logic [LEN_BITS-1:0]   clip_len;
    logic [TIME_BITS:0]    acc_sum;
    logic [DUR_BITS-1:0]   dur_eff;
    logic                  can_adv;

    logic                  ram_we;
    logic                  ram_re;
    logic [FRAME_BITS-1:0] ram_raddr;
    logic [DUR_BITS-1:0]   ram_rdata;

    step_in_t              step_in;
    step_out_t             step_out;

    assign in_mode   = s_tdata[1:0];
    assign in_tick   = s_tdata[2 +: DUR_BITS];
    assign in_index  = s_tdata[2 + DUR_BITS +: FRAME_BITS];
    assign in_dur    = s_tdata[2 + DUR_BITS + FRAME_BITS +: DUR_BITS];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign clip_len = (frame_count_reg > LEN_BITS'(MAX_FRAMES)) ?
                      LEN_BITS'(MAX_FRAMES) : frame_count_reg;
    assign acc_sum  = {1'b0, acc_reg} + (TIME_BITS + 1)'(in_tick);

    // a frame outside the clip or a zero duration counts as one tick
    assign dur_eff = ((LEN_BITS'(frame_reg) < clip_len) && (ram_rdata != '0)) ?
                     ram_rdata : DUR_BITS'(1);
    assign can_adv = playing_reg && (adv_cnt_reg < ADV_BITS'(MAX_ADVANCES)) &&
                     (acc_reg >= TIME_BITS'(dur_eff));

    assign step_in.frame     = frame_reg;
    assign step_in.len       = clip_len;
    assign step_in.loop_mode = loop_mode_reg;
    assign step_in.fwd       = fwd_reg;

    sfs_frame_step u_step (
        .step_in  (step_in),
        .step_out (step_out)
    );

    assign ram_we = in_accept && (in_mode == ITEM_LOAD);

    sfs_dur_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_index),
        .wdata (in_dur),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        frame_next       = frame_reg;
        acc_next         = acc_reg;
        fwd_next         = fwd_reg;
        playing_next     = playing_reg;
        loop_mode_next   = loop_mode_reg;
        frame_count_next = frame_count_reg;
        adv_cnt_next     = adv_cnt_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        ram_re           = 1'b0;
        ram_raddr        = frame_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_FINISH;
                    unique case (in_mode)
                        ITEM_TICK:
                        begin
                            if (playing_reg && (clip_len != '0) && (in_tick != '0))
                            begin
                                acc_next     = acc_sum[TIME_BITS] ? '1 :
                                               acc_sum[TIME_BITS-1:0];
                                adv_cnt_next = '0;
                                ram_re       = 1'b1;
                                state_next   = ST_CMP;
                            end
                        end
                        ITEM_RESTART:
                        begin
                            frame_next   = '0;
                            acc_next     = '0;
                            fwd_next     = 1'b1;
                            playing_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                if (can_adv)
                begin
                    acc_next     = acc_reg - TIME_BITS'(dur_eff);
                    frame_next   = step_out.frame;
                    fwd_next     = step_out.fwd;
                    playing_next = !step_out.stop;
                    adv_cnt_next = adv_cnt_reg + ADV_BITS'(1);
                    // fetch the next frame's duration while stepping
                    ram_re       = 1'b1;
                    ram_raddr    = step_out.frame;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {fwd_reg, playing_reg, frame_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a changed register value rewinds to frame 0, forward, with a cleared accumulator
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOOP_MODE:
                begin
                    if (cfg_data[1:0] != loop_mode_reg)
                    begin
                        loop_mode_next = cfg_data[1:0];
                        frame_next     = '0;
                        acc_next       = '0;
                        fwd_next       = 1'b1;
                    end
                end
                default:
                begin
                    if (cfg_data != frame_count_reg)
                    begin
                        frame_count_next = cfg_data;
                        frame_next       = '0;
                        acc_next         = '0;
                        fwd_next         = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            frame_reg       <= '0;
            acc_reg         <= '0;
            fwd_reg         <= 1'b1;
            playing_reg     <= 1'b1;
            loop_mode_reg   <= LOOP_WRAP;
            frame_count_reg <= '0;
            adv_cnt_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            frame_reg       <= frame_next;
            acc_reg         <= acc_next;
            fwd_reg         <= fwd_next;
            playing_reg     <= playing_next;
            loop_mode_reg   <= loop_mode_next;
            frame_count_reg <= frame_count_next;
            adv_cnt_reg     <= adv_cnt_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/core/sfs_checker.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module sfs_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [sfs_pkg::IN_BYTES*8-1:0]       s_tdata,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [sfs_pkg::OUT_BYTES*8-1:0]      m_tdata,
    input logic                                 cfg_we
);
    import sfs_pkg::*;

    logic in_beat;
    assign in_beat = s_tvalid && s_tready;

    // one item in flight: ready drops right after an input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("sfs: input taken while an item is in flight");

    // a stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("sfs: output beat changed under stall");

    // restart with the output free reports frame 0, playing, forward
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && (s_tdata[1:0] == ITEM_RESTART) && !m_tvalid && !cfg_we |->
        ##2 m_tvalid && (m_tdata[FRAME_BITS-1:0] == '0) &&
            m_tdata[FRAME_BITS] && m_tdata[FRAME_BITS+1])
        else $error("sfs: restart result wrong or late");

    // a load item with the output free delivers its result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && (s_tdata[1:0] == ITEM_LOAD) && !m_tvalid |-> ##2 m_tvalid)
        else $error("sfs: load result late");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);
